// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the datagram master checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/urdm_pkg.sv
// ----------------------------------------------------------------------------
// urdm_pkg
// Types, codes and CRC-8 helper shared by the datagram master modules
// ----------------------------------------------------------------------------
package urdm_pkg;

    // request and line codes on the input side
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_BYTE  = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_READ_OK = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd2;

    // jobs handed from front to back
    localparam logic [1:0] JOB_WRITE = 2'd0;
    localparam logic [1:0] JOB_READ  = 2'd1;
    localparam logic [1:0] JOB_DONE  = 2'd2;
    localparam logic [1:0] JOB_FAIL  = 2'd3;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] REPLY_MARK = 8'hFF;
    localparam logic       WRITE_FLAG = 1'b1;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // one byte into the crc, data bits lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int j = 0; j < 8; j++) begin
            if (c[7] ^ b[j]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_SYNC    = crc8_byte(8'h00, SYNC_BYTE);
    localparam logic [7:0] CRC_SYNC_FF = crc8_byte(CRC_SYNC, REPLY_MARK);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  node;
        logic [7:0]  addr_byte;
        logic [31:0] data;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

// File: sv/urdm_front.sv
// ----------------------------------------------------------------------------
// urdm_front
// Accepts requests, received bytes and ticks; tracks the read exchange and
// posts one job per beat that causes results
// ----------------------------------------------------------------------------
module urdm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_func,
    input  logic [6:0]        i_reg_address,
    input  logic [31:0]       i_write_data,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_fire,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output urdm_pkg::t_push   o_push
);
    import urdm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [7:0]  r_node;
    logic [7:0]  r_timeout;
    logic [2:0]  r_max_att;

    logic [1:0]  r_phase,   n_phase;
    logic [15:0] r_win,     n_win;
    logic [2:0]  r_count,   n_count;
    logic [7:0]  r_ticks,   n_ticks;
    logic [2:0]  r_att,     n_att;
    logic [6:0]  r_pending, n_pending;
    logic [7:0]  r_rx_crc,  n_rx_crc;
    logic [31:0] r_rx_data, n_rx_data;

    logic        fail;
    logic        send;
    logic [2:0]  att_base;

    always_comb begin
        n_phase   = r_phase;
        n_win     = r_win;
        n_count   = r_count;
        n_ticks   = r_ticks;
        n_att     = r_att;
        n_pending = r_pending;
        n_rx_crc  = r_rx_crc;
        n_rx_data = r_rx_data;
        fail      = 1'b0;
        send      = 1'b0;
        att_base  = r_att;
        o_push    = '0;

        case (i_func)
            FUNC_WRITE: begin
                n_phase                = PH_IDLE;
                o_push.valid           = 1'b1;
                o_push.job.op          = JOB_WRITE;
                o_push.job.node        = r_node;
                o_push.job.addr_byte   = {WRITE_FLAG, i_reg_address};
                o_push.job.data        = i_write_data;
            end
            FUNC_READ: begin
                n_pending = i_reg_address;
                att_base  = 3'd0;
                send      = 1'b1;
            end
            FUNC_BYTE: begin
                if (r_phase == PH_SCAN) begin
                    n_win = {r_win[7:0], i_rx_byte};
                    if ({r_win, i_rx_byte} == {SYNC_BYTE, REPLY_MARK, 1'b0, r_pending}) begin
                        n_phase  = PH_BODY;
                        n_count  = 3'd0;
                        n_ticks  = r_timeout;
                        n_rx_crc = crc8_byte(CRC_SYNC_FF, {1'b0, r_pending});
                    end
                end else if (r_phase == PH_BODY) begin
                    n_count = r_count + 3'd1;
                    if (r_count == 3'd4) begin
                        // fifth body beat carries the crc
                        if (i_rx_byte == r_rx_crc && r_rx_crc != 8'h00) begin
                            n_phase         = PH_IDLE;
                            o_push.valid    = 1'b1;
                            o_push.job.op   = JOB_DONE;
                            o_push.job.data = r_rx_data;
                        end else begin
                            fail = 1'b1;
                        end
                    end else begin
                        n_rx_crc  = crc8_byte(r_rx_crc, i_rx_byte);
                        n_rx_data = {r_rx_data[23:0], i_rx_byte};
                    end
                end
            end
            FUNC_TICK: begin
                if (r_phase == PH_SCAN || r_phase == PH_BODY) begin
                    if (r_ticks <= 8'd1) begin
                        n_ticks = 8'd0;
                        fail    = 1'b1;
                    end else begin
                        n_ticks = r_ticks - 8'd1;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (fail) begin
            if (r_att < r_max_att) begin
                send = 1'b1;
            end else begin
                n_phase       = PH_IDLE;
                o_push.valid  = 1'b1;
                o_push.job.op = JOB_FAIL;
            end
        end

        if (send) begin
            n_att                = att_base + 3'd1;
            n_phase              = PH_SCAN;
            n_win                = 16'h0000;
            n_count              = 3'd0;
            n_ticks              = r_timeout;
            o_push.valid         = 1'b1;
            o_push.job.op        = JOB_READ;
            o_push.job.node      = r_node;
            o_push.job.addr_byte = {1'b0, n_pending};
        end

        if (!i_fire) begin
            o_push.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node    <= 8'd0;
            r_timeout <= 8'd5;
            r_max_att <= 3'd2;
        end else if (i_cfg_fire) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS:  r_node    <= i_cfg_data;
                CFG_REPLY_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_MAX_ATTEMPTS:  r_max_att <= i_cfg_data[2:0];
                default:           r_node    <= r_node;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= 3'd0;
            r_ticks   <= 8'd0;
            r_att     <= 3'd0;
            r_pending <= 7'd0;
            r_win     <= 16'h0000;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_ticks   <= n_ticks;
            r_att     <= n_att;
            r_pending <= n_pending;
            r_win     <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rx_crc  <= n_rx_crc;
            r_rx_data <= n_rx_data;
        end
    end

endmodule

// File: sv/urdm_queue.sv
// ----------------------------------------------------------------------------
// urdm_queue
// Short job queue between the front and the back
// ----------------------------------------------------------------------------
module urdm_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  urdm_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output urdm_pkg::t_job  o_job
);
    import urdm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/urdm_back.sv
// ----------------------------------------------------------------------------
// urdm_back
// Turns jobs into result beats: framed request bytes with a running CRC-8,
// read completion or failure
// ----------------------------------------------------------------------------
module urdm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  urdm_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_tx_byte,
    output logic [31:0]    o_read_data,
    output logic           o_last
);
    import urdm_pkg::*;

    t_job        r_job;
    logic        r_busy,      n_busy;
    logic [2:0]  r_idx,       n_idx;
    logic [7:0]  r_crc,       n_crc;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind,      n_kind;
    logic [7:0]  r_tx,        n_tx;
    logic [31:0] r_data,      n_data;
    logic        r_last,      n_last;

    logic        out_free;
    logic        is_crc;
    logic [2:0]  final_idx;
    logic [7:0]  frame_byte;
    logic [7:0]  cur_byte;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_pop     = out_free && !r_busy && i_q_valid;
    assign final_idx = (r_job.op == JOB_WRITE) ? 3'd7 : 3'd3;
    assign is_crc    = (r_idx == final_idx);

    always_comb begin
        case (r_idx)
            3'd1:    frame_byte = r_job.node;
            3'd2:    frame_byte = r_job.addr_byte;
            3'd3:    frame_byte = r_job.data[31:24];
            3'd4:    frame_byte = r_job.data[23:16];
            3'd5:    frame_byte = r_job.data[15:8];
            3'd6:    frame_byte = r_job.data[7:0];
            default: frame_byte = SYNC_BYTE;
        endcase
        cur_byte = is_crc ? r_crc : frame_byte;
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_tx        = r_tx;
        n_data      = r_data;
        n_last      = r_last;
        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_kind      = KIND_BYTE;
                n_tx        = cur_byte;
                n_data      = 32'd0;
                n_last      = is_crc;
                n_crc       = crc8_byte(r_crc, cur_byte);
                n_idx       = r_idx + 3'd1;
                n_busy      = !is_crc;
            end else if (i_q_valid) begin
                n_out_valid = 1'b1;
                n_tx        = 8'd0;
                n_data      = 32'd0;
                n_last      = 1'b1;
                case (i_job.op)
                    JOB_WRITE, JOB_READ: begin
                        // sync beat goes out as the job is taken
                        n_kind = KIND_BYTE;
                        n_tx   = SYNC_BYTE;
                        n_last = 1'b0;
                        n_busy = 1'b1;
                        n_idx  = 3'd1;
                        n_crc  = CRC_SYNC;
                    end
                    JOB_DONE: begin
                        n_kind = KIND_READ_OK;
                        n_data = i_job.data;
                    end
                    default: begin
                        n_kind = KIND_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_crc  <= n_crc;
        r_kind <= n_kind;
        r_tx   <= n_tx;
        r_data <= n_data;
        r_last <= n_last;
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_read_data = r_data;
    assign o_last      = r_last;

endmodule

// File: sv/uart_register_datagram_master_unit.sv
// Path: an accepted beat's job is registered in the job queue, then in the back
// end's output register. A write request streams 8 byte beats, a read request
// 4; completion and failure take one beat. The back end's byte sequencer sets
// this; the front takes one beat a cycle while the job queue has room.
// Reset: synchronous, active low; clears exchange state, queue and output
// valid, and loads node_address 0, reply_timeout 5, max_attempts 2.
// ----------------------------------------------------------------------------
// uart_register_datagram_master_unit
// Master side of a UART register link: framed write/read requests with CRC-8,
// reply scan and check, timeout and resend
// ----------------------------------------------------------------------------
module uart_register_datagram_master_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [6:0]  i_reg_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_read_data,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import urdm_pkg::*;

    t_push push;
    t_job  q_job;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  in_fire;

    assign o_in_ready  = !q_full;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    urdm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_func        (i_func),
        .i_reg_address (i_reg_address),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_fire    (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push)
    );

    urdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    urdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_read_data (o_read_data),
        .o_last      (o_last)
    );

endmodule

// File: sv/urdm_checker.sv
// ----------------------------------------------------------------------------
// urdm_checker
// Port-level checks on the result channel of the datagram master
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_tx_byte,
    input logic [31:0] o_read_data,
    input logic        o_last
);
    import urdm_pkg::*;

    // a stalled beat stays offered and unchanged
    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_beat_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_kind) && $stable(o_tx_byte) && $stable(o_read_data) && $stable(o_last))

    // completion and failure are always marked last; unused fields of a beat read zero
    `ASSERT_IMPLIES(a_status_last, i_clk, i_rst_n, o_out_valid && o_kind != KIND_BYTE, o_last)
    `ASSERT_IMPLIES(a_data_zero, i_clk, i_rst_n, o_out_valid && o_kind != KIND_READ_OK, o_read_data == 32'd0)
    `ASSERT_IMPLIES(a_tx_zero, i_clk, i_rst_n, o_out_valid && o_kind != KIND_BYTE, o_tx_byte == 8'd0)

endmodule

bind uart_register_datagram_master_unit urdm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_tx_byte   (o_tx_byte),
    .o_read_data (o_read_data),
    .o_last      (o_last)
);

// File: tb/sv/uart_register_datagram_master_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_datagram_master_unit_test
// Drives write and read requests, reply bytes and ticks into the datagram
// master and checks every result beat against a predictor of the link
// ----------------------------------------------------------------------------
module uart_register_datagram_master_unit_test;
    import urdm_pkg::*;

    localparam int UNTYPED       = -1;
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 100000;

    localparam logic [1:0] LINK_IDLE = 2'd0;
    localparam logic [1:0] LINK_SCAN = 2'd1;
    localparam logic [1:0] LINK_BODY = 2'd2;

    typedef enum logic [1:0] {REPLY_GOOD, REPLY_BAD_CRC, REPLY_ZERO_CRC} t_reply_mode;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [31:0] data;
        logic        is_last;
    } t_beat;

    typedef struct {
        logic [1:0]  func;
        logic [6:0]  reg_addr;
        logic [31:0] wdata;
        logic [7:0]  rx;
        int          want_count;
        logic [1:0]  want_kind;
        logic [31:0] want_data;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = FUNC_TICK;
    logic [6:0]  i_reg_address = 7'd0;
    logic [31:0] i_write_data = 32'd0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [31:0] o_read_data;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_NODE_ADDRESS;
    logic [7:0]  i_cfg_data = 8'd0;

    uart_register_datagram_master_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_reg_address (i_reg_address),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_read_data   (o_read_data),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the link
    logic [7:0]  cfg_node    = 8'd0;
    logic [7:0]  cfg_timeout = 8'd5;
    logic [2:0]  cfg_tries   = 3'd2;
    logic [1:0]  link_phase  = LINK_IDLE;
    logic [23:0] sync_win    = '0;
    logic [63:0] reply_bits  = '0;
    logic [2:0]  body_cnt    = '0;
    logic [7:0]  ticks_rem   = '0;
    logic [2:0]  tries_made  = '0;
    logic [6:0]  pend_addr   = '0;

    t_beat     fresh_beats[$];
    t_beat     expected_beats[$];
    t_beat     head_beat;
    t_stim_row directed_rows[$];

    int   errors = 0;
    int   live_items = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;
    logic quiet_stretch = 1'b0;

    // crc-8 over the low n bytes of msg, first byte highest, lsb of each byte first
    function automatic logic [7:0] crc_of(input logic [63:0] msg, input int n);
        logic [7:0] c;
        logic [7:0] b;
        c = 8'h00;
        for (int i = 0; i < n; i++) begin
            b = msg[8 * (n - 1 - i) +: 8];
            for (int j = 0; j < 8; j++) begin
                if (c[7] ^ b[j]) begin
                    c = {c[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    c = {c[6:0], 1'b0};
                end
            end
        end
        return c;
    endfunction

    // eight reply bytes as the slave would send them
    function automatic logic [63:0] reply_frame(input logic [6:0] addr, input logic [31:0] word,
                                                input t_reply_mode mode);
        logic [55:0] body;
        logic [7:0]  c;
        logic        found;
        body  = {SYNC_BYTE, REPLY_MARK, 1'b0, addr, word};
        c     = crc_of({8'h00, body}, 7);
        found = 1'b0;
        case (mode)
            REPLY_GOOD: begin
                // a zero crc would be rejected, so nudge the data
                if (c == 8'h00) begin
                    body[0] = ~body[0];
                    c = crc_of({8'h00, body}, 7);
                end
            end
            REPLY_BAD_CRC: begin
                c = c ^ (8'h01 << $urandom_range(0, 7));
            end
            default: begin
                for (int v = 0; v < 256 && !found; v++) begin
                    body[7:0] = v[7:0];
                    found = (crc_of({8'h00, body}, 7) == 8'h00);
                end
                c = 8'h00;
            end
        endcase
        return {body, c};
    endfunction

    function automatic t_stim_row make_row(input logic [1:0] func, input logic [6:0] addr,
                                           input logic [31:0] wd, input logic [7:0] rx,
                                           input int want_count, input logic [1:0] want_kind,
                                           input logic [31:0] want_data);
        t_stim_row r;
        r.func       = func;
        r.reg_addr   = addr;
        r.wdata      = wd;
        r.rx         = rx;
        r.want_count = want_count;
        r.want_kind  = want_kind;
        r.want_data  = want_data;
        return r;
    endfunction

    task automatic put_beat(input logic [1:0] kind, input logic [7:0] tx, input logic [31:0] data);
        t_beat b;
        b.kind    = kind;
        b.tx      = tx;
        b.data    = data;
        b.is_last = 1'b0;
        fresh_beats.push_back(b);
    endtask

    task automatic issue_read_request();
        logic [23:0] hdr;
        hdr = {SYNC_BYTE, cfg_node, 1'b0, pend_addr};
        put_beat(KIND_BYTE, hdr[23:16], 32'd0);
        put_beat(KIND_BYTE, hdr[15:8], 32'd0);
        put_beat(KIND_BYTE, hdr[7:0], 32'd0);
        put_beat(KIND_BYTE, crc_of({40'd0, hdr}, 3), 32'd0);
        tries_made = tries_made + 3'd1;
        link_phase = LINK_SCAN;
        sync_win   = '0;
        reply_bits = '0;
        body_cnt   = '0;
        ticks_rem  = cfg_timeout;
    endtask

    task automatic read_attempt_failed();
        if (tries_made < cfg_tries) begin
            issue_read_request();
        end else begin
            link_phase = LINK_IDLE;
            put_beat(KIND_FAIL, 8'd0, 32'd0);
        end
    endtask

    task automatic predict_link_beats(input logic [1:0] func, input logic [6:0] addr,
                                      input logic [31:0] wd, input logic [7:0] rx);
        logic [55:0] msg;
        logic [7:0]  c;
        t_beat       b;
        fresh_beats.delete();
        case (func)
            FUNC_WRITE: begin
                link_phase = LINK_IDLE;
                msg = {SYNC_BYTE, cfg_node, WRITE_FLAG, addr, wd};
                for (int k = 0; k < 7; k++) begin
                    put_beat(KIND_BYTE, msg[55 - 8 * k -: 8], 32'd0);
                end
                put_beat(KIND_BYTE, crc_of({8'h00, msg}, 7), 32'd0);
            end
            FUNC_READ: begin
                pend_addr  = addr;
                tries_made = '0;
                issue_read_request();
            end
            FUNC_BYTE: begin
                if (link_phase == LINK_SCAN) begin
                    sync_win = {sync_win[15:0], rx};
                    if (sync_win == {SYNC_BYTE, REPLY_MARK, 1'b0, pend_addr}) begin
                        link_phase = LINK_BODY;
                        reply_bits = {40'd0, sync_win};
                        body_cnt   = '0;
                        ticks_rem  = cfg_timeout;
                    end
                end else if (link_phase == LINK_BODY) begin
                    reply_bits = {reply_bits[55:0], rx};
                    body_cnt   = body_cnt + 3'd1;
                    if (body_cnt >= 3'd5) begin
                        c = crc_of({8'h00, reply_bits[63:8]}, 7);
                        if (c != reply_bits[7:0] || c == 8'h00) begin
                            read_attempt_failed();
                        end else begin
                            link_phase = LINK_IDLE;
                            put_beat(KIND_READ_OK, 8'd0, reply_bits[39:8]);
                        end
                    end
                end
            end
            default: begin
                if (link_phase != LINK_IDLE) begin
                    if (ticks_rem <= 8'd1) begin
                        ticks_rem = '0;
                        read_attempt_failed();
                    end else begin
                        ticks_rem = ticks_rem - 8'd1;
                    end
                end
            end
        endcase
        if (fresh_beats.size() > 0) begin
            b = fresh_beats.pop_back();
            b.is_last = 1'b1;
            fresh_beats.push_back(b);
        end
    endtask

    // offer one input beat, wait for it to be taken, then predict what it causes
    task automatic drive_row(input t_stim_row r);
        if (!quiet_stretch && $urandom_range(0, 99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= r.func;
        i_reg_address <= r.reg_addr;
        i_write_data  <= r.wdata;
        i_rx_byte     <= r.rx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (r.func == FUNC_WRITE || r.func == FUNC_READ || link_phase != LINK_IDLE) begin
            live_items++;
        end
        predict_link_beats(r.func, r.reg_addr, r.wdata, r.rx);
        if (r.want_count != UNTYPED) begin
            if (fresh_beats.size() != r.want_count) begin
                $error("beat count: expected %0d, actual %0d", r.want_count, fresh_beats.size());
                errors++;
            end else if (r.want_count > 0) begin
                if (fresh_beats[r.want_count - 1].kind !== r.want_kind) begin
                    $error("kind: expected %0d, actual %0d", r.want_kind,
                           fresh_beats[r.want_count - 1].kind);
                    errors++;
                end
                if (fresh_beats[r.want_count - 1].data !== r.want_data) begin
                    $error("read_data: expected %h, actual %h", r.want_data,
                           fresh_beats[r.want_count - 1].data);
                    errors++;
                end
            end
        end
        foreach (fresh_beats[k]) expected_beats.push_back(fresh_beats[k]);
    endtask

    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] node, input logic [7:0] timeout,
                                 input logic [2:0] tries);
        logic [1:0] idx[3];
        logic [7:0] val[3];
        idx[0] = CFG_NODE_ADDRESS;
        val[0] = node;
        idx[1] = CFG_REPLY_TIMEOUT;
        val[1] = timeout;
        idx[2] = CFG_MAX_ATTEMPTS;
        val[2] = {5'd0, tries};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cfg_node    = node;
        cfg_timeout = timeout;
        cfg_tries   = tries;
    endtask

    task automatic run_random_phase(input int items);
        int          target;
        int          pick;
        int          n;
        logic [6:0]  addr;
        logic [63:0] frame;
        t_reply_mode mode;
        target = live_items + items;
        while (live_items < target) begin
            addr = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // exchange: request, some line noise, then a reply, good or corrupt
                drive_row(make_row(FUNC_READ, addr, $urandom, 8'($urandom), UNTYPED,
                                   KIND_BYTE, 32'd0));
                repeat ($urandom_range(0, 2)) begin
                    drive_row(make_row(FUNC_BYTE, 7'($urandom), $urandom, 8'($urandom),
                                       UNTYPED, KIND_BYTE, 32'd0));
                end
                if ($urandom_range(0, 3) == 0) begin
                    drive_row(make_row(FUNC_TICK, 7'($urandom), $urandom, 8'($urandom),
                                       UNTYPED, KIND_BYTE, 32'd0));
                end
                n = $urandom_range(0, 99);
                mode = (n < 70) ? REPLY_GOOD : (n < 85) ? REPLY_BAD_CRC : REPLY_ZERO_CRC;
                frame = reply_frame(addr, $urandom, mode);
                for (int k = 0; k < 8; k++) begin
                    drive_row(make_row(FUNC_BYTE, 7'($urandom), $urandom,
                                       frame[63 - 8 * k -: 8], UNTYPED, KIND_BYTE, 32'd0));
                end
                // answer the resend, if there is one
                if (mode != REPLY_GOOD && $urandom_range(0, 1) == 1) begin
                    frame = reply_frame(addr, $urandom, REPLY_GOOD);
                    for (int k = 0; k < 8; k++) begin
                        drive_row(make_row(FUNC_BYTE, 7'($urandom), $urandom,
                                           frame[63 - 8 * k -: 8], UNTYPED, KIND_BYTE, 32'd0));
                    end
                end
            end else if (pick < 70) begin
                drive_row(make_row(FUNC_WRITE, addr, $urandom, 8'($urandom), UNTYPED,
                                   KIND_BYTE, 32'd0));
            end else if (pick < 80) begin
                drive_row(make_row(FUNC_READ, addr, $urandom, 8'($urandom), UNTYPED,
                                   KIND_BYTE, 32'd0));
                repeat ($urandom_range(1, 8)) begin
                    drive_row(make_row(FUNC_TICK, 7'($urandom), $urandom, 8'($urandom),
                                       UNTYPED, KIND_BYTE, 32'd0));
                end
            end else if (pick < 90) begin
                drive_row(make_row($urandom_range(0, 1) ? FUNC_BYTE : FUNC_TICK, addr,
                                   $urandom, 8'($urandom), UNTYPED, KIND_BYTE, 32'd0));
            end else begin
                // broken exchange: a new request cuts the reply short
                drive_row(make_row(FUNC_READ, addr, $urandom, 8'($urandom), UNTYPED,
                                   KIND_BYTE, 32'd0));
                frame = reply_frame(addr, $urandom, REPLY_GOOD);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    drive_row(make_row(FUNC_BYTE, 7'($urandom), $urandom,
                                       frame[63 - 8 * k -: 8], UNTYPED, KIND_BYTE, 32'd0));
                end
                drive_row(make_row($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                                   7'($urandom), $urandom, 8'($urandom), UNTYPED,
                                   KIND_BYTE, 32'd0));
            end
        end
    endtask

    // result side: check each beat taken, then choose ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d tx_byte %h read_data %h",
                       o_kind, o_tx_byte, o_read_data);
                errors++;
            end else begin
                head_beat = expected_beats.pop_front();
                if (o_kind !== head_beat.kind) begin
                    $error("kind: expected %0d, actual %0d", head_beat.kind, o_kind);
                    errors++;
                end
                if (o_tx_byte !== head_beat.tx) begin
                    $error("tx_byte: expected %h, actual %h", head_beat.tx, o_tx_byte);
                    errors++;
                end
                if (o_read_data !== head_beat.data) begin
                    $error("read_data: expected %h, actual %h", head_beat.data, o_read_data);
                    errors++;
                end
                if (o_last !== head_beat.is_last) begin
                    $error("last: expected %0d, actual %0d", head_beat.is_last, o_last);
                    errors++;
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_register_datagram_master_unit_test failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] frame;

        // idle line traffic, then a write with address and data at zero
        directed_rows.push_back(make_row(FUNC_BYTE, 7'd0, 32'd0, 8'hFF, 0, KIND_BYTE, 0));
        directed_rows.push_back(make_row(FUNC_TICK, 7'd0, 32'd0, 8'h00, 0, KIND_BYTE, 0));
        directed_rows.push_back(make_row(FUNC_WRITE, 7'd0, 32'd0, 8'h00, 8, KIND_BYTE, 0));
        // clean read of the top register
        directed_rows.push_back(make_row(FUNC_READ, 7'h7F, 32'd0, 8'h00, 4, KIND_BYTE, 0));
        frame = reply_frame(7'h7F, 32'h89AB_CDEF, REPLY_GOOD);
        for (int k = 0; k < 8; k++) begin
            directed_rows.push_back(make_row(FUNC_BYTE, 7'd0, 32'd0, frame[63 - 8 * k -: 8],
                                             (k == 7) ? 1 : 0, KIND_READ_OK, frame[39:8]));
        end
        // zero crc forces a resend, then the second attempt times out
        directed_rows.push_back(make_row(FUNC_READ, 7'd0, 32'd0, 8'h00, 4, KIND_BYTE, 0));
        frame = reply_frame(7'd0, 32'h0000_0000, REPLY_ZERO_CRC);
        for (int k = 0; k < 8; k++) begin
            directed_rows.push_back(make_row(FUNC_BYTE, 7'd0, 32'd0, frame[63 - 8 * k -: 8],
                                             (k == 7) ? 4 : 0, KIND_BYTE, 0));
        end
        for (int k = 0; k < 5; k++) begin
            directed_rows.push_back(make_row(FUNC_TICK, 7'd0, 32'd0, 8'h00,
                                             (k == 4) ? 1 : 0, KIND_FAIL, 0));
        end
        // a write abandons the pending read
        directed_rows.push_back(make_row(FUNC_READ, 7'h2A, 32'd0, 8'h00, 4, KIND_BYTE, 0));
        directed_rows.push_back(make_row(FUNC_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'h00, 8,
                                         KIND_BYTE, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) drive_row(directed_rows[k]);
        drain(SETTLE_CYCLES);

        load_settings(8'hFF, 8'd1, 3'd1);
        // stall the result side while writes keep coming, then wait for all of them
        hold_request = 1'b1;
        repeat (6) begin
            drive_row(make_row(FUNC_WRITE, 7'($urandom), $urandom, 8'($urandom), UNTYPED,
                               KIND_BYTE, 32'd0));
        end
        drain(SETTLE_CYCLES);
        run_random_phase(14);
        drain(SETTLE_CYCLES);

        quiet_stretch = 1'b1;
        load_settings(8'h00, 8'hFF, 3'd7);
        run_random_phase(14);
        drain(SETTLE_CYCLES);
        quiet_stretch = 1'b0;

        load_settings(8'($urandom), 8'($urandom_range(2, 6)), 3'($urandom_range(1, 7)));
        run_random_phase(14);
        drain(SETTLE_CYCLES);

        // zero timeout and zero attempts both behave as one
        load_settings(8'($urandom), 8'd0, 3'd0);
        run_random_phase(10);
        drain(FINAL_CYCLES);

        if (errors == 0) begin
            $display("uart_register_datagram_master_unit_test passed");
        end else begin
            $display("uart_register_datagram_master_unit_test failed");
        end
        $finish;
    end

endmodule
